/* design/gtsb_pkg.sv */
package gtsb_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PAYOFF_CC  = 3'd0,
    CFG_PAYOFF_CD  = 3'd1,
    CFG_PAYOFF_DC  = 3'd2,
    CFG_PAYOFF_DD  = 3'd3,
    CFG_SELECTION  = 3'd4,
    CFG_FERTILITY  = 3'd5,
    CFG_CROWDING   = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_COOP   = 2'd0,
    KIND_DEFECT = 2'd1,
    KIND_NONE   = 2'd2
  } event_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FC, ST_FD, ST_PC0, ST_PC1, ST_F1, ST_PD0, ST_PD1, ST_F2,
    ST_PHI0, ST_PHI1, ST_G0, ST_G1, ST_CHKC, ST_QC, ST_TC, ST_RC,
    ST_CHKD, ST_QD, ST_TD, ST_RD, ST_TOTAL, ST_NORM, ST_SQ, ST_LN,
    ST_TAU, ST_SCALE, ST_PICK, ST_DONE
  } state_t;

  localparam logic [27:0]  LN2_Q28  = 28'd186065279;
  localparam logic [127:0] PROD_CAP = 128'h4000_0000_0000_0000;
  localparam logic [47:0]  RATE_CAP = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0]  TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] a;      // multiplicand or dividend
    logic [63:0] b;      // multiplier or divisor
  } arith_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;   // one-cycle pulse, results held after
    logic [127:0] prod;
    logic [63:0]  quot;
  } arith_stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

/* design/gtsb_arith.sv */
// Shared iterative unit: 64x64 multiply, 8 multiplier bits per cycle with
// early stop once the remaining bits are zero; 64/64 restoring divide,
// one quotient bit per cycle.
module gtsb_arith (
  input  logic                   clk,
  input  logic                   rst,
  input  gtsb_pkg::arith_req_t   req,
  output gtsb_pkg::arith_stat_t  stat
);

  logic         busy;
  logic         done;
  logic         is_div;
  logic [127:0] a_sh;
  logic [63:0]  mb;
  logic [127:0] acc;
  logic [64:0]  rem;
  logic [63:0]  quo;
  logic [63:0]  dvs;
  logic [5:0]   cnt;

  logic [64:0]  rem_sh;
  logic [64:0]  rem_next;
  logic         q_bit;

  always_comb begin
    rem_sh = {rem[63:0], quo[63]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = rem_sh - {1'b0, dvs};
      q_bit    = 1'b1;
    end else begin
      rem_next = rem_sh;
      q_bit    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        a_sh   <= 128'(req.a);
        mb     <= req.b;
        acc    <= '0;
        rem    <= '0;
        quo    <= req.a;
        dvs    <= req.b;
        cnt    <= 6'd63;
      end else if (busy) begin
        if (is_div) begin
          rem <= rem_next;
          quo <= {quo[62:0], q_bit};
          if (cnt == 6'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end else if (mb == 64'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          acc  <= acc + a_sh * mb[7:0];
          a_sh <= a_sh << 8;
          mb   <= mb >> 8;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.prod = acc;
  assign stat.quot = quo;

endmodule

/* design/gillespie_two_species_birth_step_core.sv */
// Channel  Dir  Width  Contents
// s_*      in   64     word: time_draw, event_draw
// m_*      out  80+3   word: elapsed_time, coop_total, defect_total; user: kind, saturated
// cfg_*    in   3+16   register write, index and data
//
// The time a word takes is set by the shared unit: a word issues up to five
// divides and a series of multiplies, and the log takes thirty squarings.
// With an empty population a word goes straight to its result without the unit.
// Reset (rst, synchronous) loads the default registers, counts of 2 and time 0.
// s_tready is high only between words; a finished word sits in the output
// register until taken, and the next one is accepted meanwhile.
module gillespie_two_species_birth_step_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [31:0] time_draw, [63:32] event_draw
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // [47:0] elapsed_time, [63:48] coop_total,
                                  // [79:64] defect_total
  output logic [2:0]   m_tuser,   // [1:0] event_kind, [2] count_saturated
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_data
);

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  gtsb_pkg::state_t state, state_next;

  // configuration
  logic signed [15:0] cc, cd, dc, dd;
  logic [15:0] sel_s, fert_p, crowd_b;

  // architectural state
  logic [COUNT_BITS-1:0] coop_count, defect_count;
  logic [47:0]           sim_time;

  // per-word working registers
  logic [31:0]        u1, u2;
  logic [16:0]        fc, fd;
  logic signed [63:0] pacc, f1, f2, phi, g;
  logic [63:0]        q;
  logic [46:0]        t;
  logic [47:0]        rc, rd, sc, sd;
  logic [31:0]        m, x;
  logic [4:0]         k, i;
  logic [29:0]        frac;
  logic [37:0]        lval;
  logic [63:0]        tau;
  gtsb_pkg::event_kind_t kind;
  logic               issued;

  gtsb_pkg::arith_req_t  req;
  gtsb_pkg::arith_stat_t stat;

  logic               uses_unit, op_div, op_neg, step_done;
  logic [63:0]        op_a, op_b;
  logic signed [63:0] sprod;
  logic [COUNT_BITS:0] n;
  logic [48:0]        total;
  logic [48:0]        scaled_sum;
  logic [35:0]        l2;
  logic [32:0]        x2;
  logic [127:0]       tcap;
  logic               ok_c, ok_d, out_free;
  logic [COUNT_BITS-1:0] c_next, d_next;
  logic [47:0]        time_next;
  logic               sat_next;
  logic [64:0]        time_sum;

  gtsb_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  assign n          = {1'b0, coop_count} + {1'b0, defect_count};
  assign total      = {1'b0, rc} + {1'b0, rd};
  assign scaled_sum = {1'b0, sc} + {1'b0, sd};
  assign l2         = {6'({1'b0, k}) + 6'd1, 30'h0} - {6'h0, frac};
  assign x2         = stat.prod[63:31];
  assign tcap       = (stat.prod > gtsb_pkg::PROD_CAP) ? gtsb_pkg::PROD_CAP : stat.prod;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == gtsb_pkg::ST_IDLE);

  // a rate is kept only where its sign product is positive
  assign ok_c = (g != 0) && (f1 != 0) && (phi != 0) && (coop_count != 0) &&
                !(g[63] ^ f1[63] ^ phi[63]);
  assign ok_d = (g != 0) && (f2 != 0) && (phi != 0) && (defect_count != 0) &&
                !(g[63] ^ f2[63] ^ phi[63]);

  // operand routing to the shared unit; signs ride beside the magnitudes
  always_comb begin
    uses_unit = 1'b1;
    op_div    = 1'b0;
    op_neg    = 1'b0;
    op_a      = '0;
    op_b      = '0;
    unique case (state)
      gtsb_pkg::ST_FC: begin
        op_div = 1'b1; op_a = 64'({coop_count, 16'h0}); op_b = 64'(n);
      end
      gtsb_pkg::ST_FD: begin
        op_div = 1'b1; op_a = 64'({defect_count, 16'h0}); op_b = 64'(n);
      end
      gtsb_pkg::ST_PC0: begin
        op_a = gtsb_pkg::mag64(64'(cc)); op_b = 64'(fc); op_neg = cc[15];
      end
      gtsb_pkg::ST_PC1: begin
        op_a = gtsb_pkg::mag64(64'(cd)); op_b = 64'(fd); op_neg = cd[15];
      end
      gtsb_pkg::ST_PD0: begin
        op_a = gtsb_pkg::mag64(64'(dc)); op_b = 64'(fc); op_neg = dc[15];
      end
      gtsb_pkg::ST_PD1: begin
        op_a = gtsb_pkg::mag64(64'(dd)); op_b = 64'(fd); op_neg = dd[15];
      end
      gtsb_pkg::ST_F1, gtsb_pkg::ST_F2: begin
        op_a = 64'(sel_s); op_b = gtsb_pkg::mag64(pacc); op_neg = pacc[63];
      end
      gtsb_pkg::ST_PHI0: begin
        op_a = gtsb_pkg::mag64(f1); op_b = 64'(fc); op_neg = f1[63];
      end
      gtsb_pkg::ST_PHI1: begin
        op_a = gtsb_pkg::mag64(f2); op_b = 64'(fd); op_neg = f2[63];
      end
      gtsb_pkg::ST_G0: begin
        op_a = 64'(fert_p); op_b = 64'(fc);
      end
      gtsb_pkg::ST_G1: begin
        op_a = 64'(crowd_b); op_b = 64'(n);
      end
      gtsb_pkg::ST_QC: begin
        op_div = 1'b1; op_a = gtsb_pkg::mag64(f1) << 32; op_b = gtsb_pkg::mag64(phi);
      end
      gtsb_pkg::ST_QD: begin
        op_div = 1'b1; op_a = gtsb_pkg::mag64(f2) << 32; op_b = gtsb_pkg::mag64(phi);
      end
      gtsb_pkg::ST_TC, gtsb_pkg::ST_TD: begin
        op_a = gtsb_pkg::mag64(g); op_b = q;
      end
      gtsb_pkg::ST_RC: begin
        op_a = 64'(t); op_b = 64'(coop_count);
      end
      gtsb_pkg::ST_RD: begin
        op_a = 64'(t); op_b = 64'(defect_count);
      end
      gtsb_pkg::ST_SQ: begin
        op_a = 64'(x); op_b = 64'(x);
      end
      gtsb_pkg::ST_LN: begin
        op_a = 64'(l2); op_b = 64'(gtsb_pkg::LN2_Q28);
      end
      gtsb_pkg::ST_TAU: begin
        op_div = 1'b1; op_a = 64'({lval, 16'h0}); op_b = 64'(total);
      end
      gtsb_pkg::ST_PICK: begin
        op_a = 64'(u2); op_b = 64'(scaled_sum);
      end
      default: uses_unit = 1'b0;
    endcase
  end

  assign req.start  = uses_unit && !issued;
  assign req.is_div = op_div;
  assign req.a      = op_a;
  assign req.b      = op_b;
  assign step_done  = uses_unit && issued && stat.done;
  assign sprod      = op_neg ? -$signed(stat.prod[63:0]) : $signed(stat.prod[63:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
    end else if (req.start) begin
      issued <= 1'b1;
    end else if (stat.done) begin
      issued <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gtsb_pkg::ST_IDLE:
        if (s_tvalid) begin
          state_next = (n != 0) ? gtsb_pkg::ST_FC : gtsb_pkg::ST_TOTAL;
        end
      gtsb_pkg::ST_FC:   if (step_done) state_next = gtsb_pkg::ST_FD;
      gtsb_pkg::ST_FD:   if (step_done) state_next = gtsb_pkg::ST_PC0;
      gtsb_pkg::ST_PC0:  if (step_done) state_next = gtsb_pkg::ST_PC1;
      gtsb_pkg::ST_PC1:  if (step_done) state_next = gtsb_pkg::ST_F1;
      gtsb_pkg::ST_F1:   if (step_done) state_next = gtsb_pkg::ST_PD0;
      gtsb_pkg::ST_PD0:  if (step_done) state_next = gtsb_pkg::ST_PD1;
      gtsb_pkg::ST_PD1:  if (step_done) state_next = gtsb_pkg::ST_F2;
      gtsb_pkg::ST_F2:   if (step_done) state_next = gtsb_pkg::ST_PHI0;
      gtsb_pkg::ST_PHI0: if (step_done) state_next = gtsb_pkg::ST_PHI1;
      gtsb_pkg::ST_PHI1: if (step_done) state_next = gtsb_pkg::ST_G0;
      gtsb_pkg::ST_G0:   if (step_done) state_next = gtsb_pkg::ST_G1;
      gtsb_pkg::ST_G1:   if (step_done) state_next = gtsb_pkg::ST_CHKC;
      gtsb_pkg::ST_CHKC:
        state_next = ok_c ? gtsb_pkg::ST_QC : gtsb_pkg::ST_CHKD;
      gtsb_pkg::ST_QC:   if (step_done) state_next = gtsb_pkg::ST_TC;
      gtsb_pkg::ST_TC:   if (step_done) state_next = gtsb_pkg::ST_RC;
      gtsb_pkg::ST_RC:   if (step_done) state_next = gtsb_pkg::ST_CHKD;
      gtsb_pkg::ST_CHKD:
        state_next = ok_d ? gtsb_pkg::ST_QD : gtsb_pkg::ST_TOTAL;
      gtsb_pkg::ST_QD:   if (step_done) state_next = gtsb_pkg::ST_TD;
      gtsb_pkg::ST_TD:   if (step_done) state_next = gtsb_pkg::ST_RD;
      gtsb_pkg::ST_RD:   if (step_done) state_next = gtsb_pkg::ST_TOTAL;
      gtsb_pkg::ST_TOTAL:
        state_next = (total == 0) ? gtsb_pkg::ST_DONE : gtsb_pkg::ST_NORM;
      gtsb_pkg::ST_NORM: if (m[31]) state_next = gtsb_pkg::ST_SQ;
      gtsb_pkg::ST_SQ:   if (step_done && i == 5'd0) state_next = gtsb_pkg::ST_LN;
      gtsb_pkg::ST_LN:   if (step_done) state_next = gtsb_pkg::ST_TAU;
      gtsb_pkg::ST_TAU:  if (step_done) state_next = gtsb_pkg::ST_SCALE;
      gtsb_pkg::ST_SCALE:
        if (scaled_sum[48:32] == 17'd0) state_next = gtsb_pkg::ST_PICK;
      gtsb_pkg::ST_PICK: if (step_done) state_next = gtsb_pkg::ST_DONE;
      gtsb_pkg::ST_DONE: if (out_free) state_next = gtsb_pkg::ST_IDLE;
      default:           state_next = gtsb_pkg::ST_IDLE;
    endcase
  end

  // working datapath: draws loaded at word start, results captured as each step of the unit finishes
  always_ff @(posedge clk) begin
    unique case (state)
      gtsb_pkg::ST_IDLE:
        if (s_tvalid) begin
          u1 <= s_tdata[31:0];
          u2 <= s_tdata[63:32];
          rc <= '0;
          rd <= '0;
        end
      gtsb_pkg::ST_FC:   if (step_done) fc <= stat.quot[16:0];
      gtsb_pkg::ST_FD:   if (step_done) fd <= stat.quot[16:0];
      gtsb_pkg::ST_PC0, gtsb_pkg::ST_PD0: if (step_done) pacc <= sprod;
      gtsb_pkg::ST_PC1, gtsb_pkg::ST_PD1: if (step_done) pacc <= pacc + sprod;
      gtsb_pkg::ST_F1:   if (step_done) f1 <= 64'sd65536 + (sprod >>> 28);
      gtsb_pkg::ST_F2:   if (step_done) f2 <= 64'sd65536 + (sprod >>> 28);
      gtsb_pkg::ST_PHI0: if (step_done) phi <= sprod;
      gtsb_pkg::ST_PHI1: if (step_done) phi <= phi + sprod;
      gtsb_pkg::ST_G0:
        if (step_done) g <= 64'sd65536 + $signed(64'(stat.prod[63:8]));
      gtsb_pkg::ST_G1:   if (step_done) g <= g - $signed(stat.prod[63:0]);
      gtsb_pkg::ST_QC, gtsb_pkg::ST_QD: if (step_done) q <= stat.quot;
      gtsb_pkg::ST_TC, gtsb_pkg::ST_TD: if (step_done) t <= tcap[62:16];
      gtsb_pkg::ST_RC:
        if (step_done) begin
          rc <= (stat.prod > 128'(gtsb_pkg::RATE_CAP)) ? gtsb_pkg::RATE_CAP
                                                       : stat.prod[47:0];
        end
      gtsb_pkg::ST_RD:
        if (step_done) begin
          rd <= (stat.prod > 128'(gtsb_pkg::RATE_CAP)) ? gtsb_pkg::RATE_CAP
                                                       : stat.prod[47:0];
        end
      gtsb_pkg::ST_TOTAL: begin
        m    <= (u1 == 32'd0) ? 32'd1 : u1;
        k    <= '0;
        kind <= gtsb_pkg::KIND_NONE;
      end
      gtsb_pkg::ST_NORM:
        if (m[31]) begin
          x    <= m;
          i    <= 5'd29;
          frac <= '0;
        end else begin
          m <= m << 1;
          k <= k + 5'd1;
        end
      gtsb_pkg::ST_SQ:
        if (step_done) begin
          // square lands in [1,4); fold back to [1,2) and emit a log bit
          if (x2[32]) begin
            x       <= x2[32:1];
            frac[i] <= 1'b1;
          end else begin
            x <= x2[31:0];
          end
          i <= i - 5'd1;
        end
      gtsb_pkg::ST_LN:   if (step_done) lval <= stat.prod[63:26];
      gtsb_pkg::ST_TAU:
        if (step_done) begin
          tau <= stat.quot;
          sc  <= rc;
          sd  <= rd;
        end
      gtsb_pkg::ST_SCALE:
        if (scaled_sum[48:32] != 17'd0) begin
          sc <= sc >> 1;
          sd <= sd >> 1;
        end
      gtsb_pkg::ST_PICK:
        if (step_done) begin
          kind <= (stat.prod[63:0] < {sc[31:0], 32'h0}) ? gtsb_pkg::KIND_COOP
                                                        : gtsb_pkg::KIND_DEFECT;
        end
      default: ;
    endcase
  end

  // end-of-step state update
  always_comb begin
    c_next    = coop_count;
    d_next    = defect_count;
    sat_next  = 1'b0;
    time_sum  = {17'h0, sim_time} + {1'b0, tau};
    time_next = (time_sum > 65'(gtsb_pkg::TIME_MAX)) ? gtsb_pkg::TIME_MAX
                                                     : time_sum[47:0];
    case (kind)
      gtsb_pkg::KIND_COOP:
        if (coop_count == CMAX) sat_next = 1'b1;
        else c_next = coop_count + COUNT_BITS'(1);
      gtsb_pkg::KIND_DEFECT:
        if (defect_count == CMAX) sat_next = 1'b1;
        else d_next = defect_count + COUNT_BITS'(1);
      default: time_next = gtsb_pkg::TIME_MAX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc           <= 16'sd8192;
      cd           <= -16'sd4096;
      dc           <= 16'sd12288;
      dd           <= 16'sd0;
      sel_s        <= 16'd6554;
      fert_p       <= 16'd2560;
      crowd_b      <= 16'd655;
      coop_count   <= COUNT_BITS'(2);
      defect_count <= COUNT_BITS'(2);
      sim_time     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          gtsb_pkg::CFG_PAYOFF_CC: cc      <= cfg_data;
          gtsb_pkg::CFG_PAYOFF_CD: cd      <= cfg_data;
          gtsb_pkg::CFG_PAYOFF_DC: dc      <= cfg_data;
          gtsb_pkg::CFG_PAYOFF_DD: dd      <= cfg_data;
          gtsb_pkg::CFG_SELECTION: sel_s   <= cfg_data;
          gtsb_pkg::CFG_FERTILITY: fert_p  <= cfg_data;
          gtsb_pkg::CFG_CROWDING:  crowd_b <= cfg_data;
          default: ;
        endcase
      end
      // a new word replaces the one taken in the same cycle
      if (state == gtsb_pkg::ST_DONE && out_free) begin
        coop_count   <= c_next;
        defect_count <= d_next;
        sim_time     <= time_next;
        m_tvalid     <= 1'b1;
        m_tdata      <= {16'(d_next), 16'(c_next), time_next};
        m_tuser      <= {sat_next, kind};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // counts never move while a finished word is stalled
  a_stall_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(coop_count) && $stable(defect_count))
    else $error("counts changed under output stall");

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !stat.busy)
    else $error("shared unit started while busy");

  a_none_unsat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == gtsb_pkg::KIND_NONE |-> !m_tuser[2])
    else $error("saturation flagged without an event");

  a_sq_norm: assert property (@(posedge clk) disable iff (rst)
    state == gtsb_pkg::ST_SQ |-> x[31])
    else $error("log operand not normalized");

endmodule

/* dv/tb_gillespie_two_species_birth_step_core.sv */
module tb_gillespie_two_species_birth_step_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 2;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          SETTLE_WAIT = 40;
  localparam int          RANDOM_WORDS = 1200;
  localparam bit [63:0]   PRODUCT_CEIL = 64'h4000_0000_0000_0000;
  localparam bit [63:0]   COUNT_MAX    = 64'd65535;

  // one result word as the block reports it
  typedef struct packed {
    logic [47:0] elapsed;
    logic [15:0] coop;
    logic [15:0] defect;
    gtsb_pkg::event_kind_t kind;
    logic        saturated;
  } birth_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // [31:0] time_draw, [63:32] event_draw
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;        // [47:0] elapsed_time, [63:48] coop_total,
                                // [79:64] defect_total
  logic [2:0]   m_tuser;        // [1:0] event_kind, [2] count_saturated
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_data = '0;

  gillespie_two_species_birth_step_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and of the population state
  // ---------------------------------------------------------------------------
  logic [15:0] pay_cc, pay_cd, pay_dc, pay_dd;
  logic [15:0] sel_s, fert_p, crowd_beta;
  bit   [63:0] coop_n, defect_n, clock_q16;

  birth_word_t expected_words[$];
  int          error_count = 0;

  task automatic reset_population_model();
    pay_cc     = 16'd8192;
    pay_cd     = 16'hF000;
    pay_dc     = 16'd12288;
    pay_dd     = 16'd0;
    sel_s      = 16'd6554;
    fert_p     = 16'd2560;
    crowd_beta = 16'd655;
    coop_n     = 2;
    defect_n   = 2;
    clock_q16  = 0;
  endtask

  function automatic bit [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // product capped at 2^62
  function automatic bit [63:0] capped_mul(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    if (a == 0 || b == 0) return 0;
    if (a > PRODUCT_CEIL / b) return PRODUCT_CEIL;
    r = a * b;
    return r > PRODUCT_CEIL ? PRODUCT_CEIL : r;
  endfunction

  // rate of one species; zero whenever the sign of g*f*phi is not positive
  function automatic bit [63:0] species_rate(longint g, longint f, bit [63:0] n, longint phi);
    bit [63:0] q, t, r;
    bit        negative;
    negative = ((g < 0) != (f < 0)) != (phi < 0);
    if (g == 0 || f == 0 || phi == 0 || n == 0 || negative) return 0;
    q = (magnitude(f) << 32) / magnitude(phi);
    t = capped_mul(magnitude(g), q) >> 16;
    r = capped_mul(t, n);
    return r > 64'(gtsb_pkg::RATE_CAP) ? 64'(gtsb_pkg::RATE_CAP) : r;
  endfunction

  // -ln(u/2^32) in Q.32, via log2 by repeated squaring
  function automatic bit [63:0] neg_log_draw(bit [31:0] u);
    bit [63:0] m, x, frac, l2;
    int        k;
    frac = 0;
    k    = 0;
    m    = (u == 0) ? 64'd1 : 64'(u);   // zero draw counts as the smallest one
    while (m < 64'h8000_0000) begin
      m <<= 1;
      k++;
    end
    x = m;
    for (int i = 29; i >= 0; i--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x >>= 1;
        frac[i] = 1'b1;
      end
    end
    l2 = (64'(k + 1) << 30) - frac;
    return (l2 * 64'(gtsb_pkg::LN2_Q28)) >> 26;
  endfunction

  // advance the population model by one step and return the word it reports
  function automatic birth_word_t predict_birth_step(bit [31:0] u1, bit [31:0] u2);
    birth_word_t w;
    bit [63:0]   n, rc, rd, total, tau, sc, sd;
    longint      fc, fd, s, pc, pd, f1, f2, phi, g;
    n  = coop_n + defect_n;
    rc = 0;
    rd = 0;
    w.saturated = 1'b0;
    if (n != 0) begin
      fc  = longint'((coop_n << 16) / n);
      fd  = longint'((defect_n << 16) / n);
      s   = longint'(sel_s);
      pc  = longint'($signed(pay_cc)) * fc + longint'($signed(pay_cd)) * fd;
      pd  = longint'($signed(pay_dc)) * fc + longint'($signed(pay_dd)) * fd;
      f1  = 65536 + ((s * pc) >>> 28);
      f2  = 65536 + ((s * pd) >>> 28);
      phi = f1 * fc + f2 * fd;
      g   = 65536 + ((longint'(fert_p) * fc) >>> 8) - longint'(crowd_beta) * longint'(n);
      rc  = species_rate(g, f1, coop_n, phi);
      rd  = species_rate(g, f2, defect_n, phi);
    end
    total = rc + rd;
    if (total == 0) begin
      // no event: the wait is infinite
      w.kind    = gtsb_pkg::KIND_NONE;
      clock_q16 = 64'(gtsb_pkg::TIME_MAX);
    end else begin
      tau = (neg_log_draw(u1) << 16) / total;
      sc  = rc;
      sd  = rd;
      while (sc + sd >= 64'h1_0000_0000) begin
        sc >>= 1;
        sd >>= 1;
      end
      clock_q16 = (tau > 64'(gtsb_pkg::TIME_MAX) - clock_q16) ? 64'(gtsb_pkg::TIME_MAX)
                                                              : clock_q16 + tau;
      if (64'(u2) * (sc + sd) < (sc << 32)) begin
        w.kind = gtsb_pkg::KIND_COOP;
        if (coop_n >= COUNT_MAX) begin
          coop_n      = COUNT_MAX;
          w.saturated = 1'b1;
        end else coop_n = coop_n + 1;
      end else begin
        w.kind = gtsb_pkg::KIND_DEFECT;
        if (defect_n >= COUNT_MAX) begin
          defect_n    = COUNT_MAX;
          w.saturated = 1'b1;
        end else defect_n = defect_n + 1;
      end
    end
    w.elapsed = clock_q16[47:0];
    w.coop    = coop_n[15:0];
    w.defect  = defect_n[15:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // offer one word and wait for the handshake; valid stays up afterwards
  task automatic send_draws(bit [31:0] u1, bit [31:0] u2);
    s_tdata  <= {u2, u1};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(predict_birth_step(u1, u2));
  endtask

  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait until every predicted word has come back, then let the core go idle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(gtsb_pkg::cfg_index_t idx, logic [15:0] value);
    cfg_addr <= idx;
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      gtsb_pkg::CFG_PAYOFF_CC: pay_cc     = value;
      gtsb_pkg::CFG_PAYOFF_CD: pay_cd     = value;
      gtsb_pkg::CFG_PAYOFF_DC: pay_dc     = value;
      gtsb_pkg::CFG_PAYOFF_DD: pay_dd     = value;
      gtsb_pkg::CFG_SELECTION: sel_s      = value;
      gtsb_pkg::CFG_FERTILITY: fert_p     = value;
      gtsb_pkg::CFG_CROWDING:  crowd_beta = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [15:0] cc, logic [15:0] cd, logic [15:0] dc,
                                logic [15:0] dd, logic [15:0] s, logic [15:0] p,
                                logic [15:0] beta);
    write_reg(gtsb_pkg::CFG_PAYOFF_CC, cc);
    write_reg(gtsb_pkg::CFG_PAYOFF_CD, cd);
    write_reg(gtsb_pkg::CFG_PAYOFF_DC, dc);
    write_reg(gtsb_pkg::CFG_PAYOFF_DD, dd);
    write_reg(gtsb_pkg::CFG_SELECTION, s);
    write_reg(gtsb_pkg::CFG_FERTILITY, p);
    write_reg(gtsb_pkg::CFG_CROWDING, beta);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls in modes of random length; a requested hold drops tready
  // for a long stretch so the core backs up into its input
  // ---------------------------------------------------------------------------
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 1500);
      end else mode_left <= mode_left - 1;
      case (stall_mode)
        0:       m_tready <= 1'b1;                           // no stalls
        1:       m_tready <= ($urandom_range(0, 99) < 70);
        2:       m_tready <= ($urandom_range(0, 99) < 10);   // mostly stalled
        default: m_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    $display("MISMATCH %s: expected %0h got %0h (word %0d pending)",
             what, want, got, expected_words.size());
  endtask

  always @(posedge clk) begin : result_check
    birth_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'd0, m_tdata[63:0]);
      end else begin
        want = expected_words.pop_front();
        if (m_tdata[47:0] !== want.elapsed)
          report_mismatch("elapsed_time", 64'(want.elapsed), 64'(m_tdata[47:0]));
        if (m_tdata[63:48] !== want.coop)
          report_mismatch("coop_total", 64'(want.coop), 64'(m_tdata[63:48]));
        if (m_tdata[79:64] !== want.defect)
          report_mismatch("defect_total", 64'(want.defect), 64'(m_tdata[79:64]));
        if (m_tuser[1:0] !== want.kind)
          report_mismatch("event_kind", 64'(want.kind), 64'(m_tuser[1:0]));
        if (m_tuser[2] !== want.saturated)
          report_mismatch("count_saturated", 64'(want.saturated), 64'(m_tuser[2]));
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** gillespie_two_species_birth_step_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset registers, extreme draws including a zero time draw
  task automatic test_default_draws();
    send_draws(32'h0000_0000, 32'h0000_0000);
    send_draws(32'h0000_0001, 32'hFFFF_FFFF);
    send_draws(32'hFFFF_FFFF, 32'h0000_0000);
    send_draws(32'h8000_0000, 32'h8000_0000);
    send_draws(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_draws(32'hAAAA_AAAA, 32'h5555_5555);
    send_draws(32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();
  endtask

  // extreme register values: negative fitness, big selection and fertility
  task automatic test_register_extremes();
    write_all_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_draws(32'h0000_0001, 32'h0000_0000);
    send_draws(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_draws(32'h1234_5678, 32'h8765_4321);
    drain_results();
    write_all_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
    send_draws(32'h0000_0000, 32'h4000_0000);
    send_draws(32'hC000_0000, 32'hC000_0000);
    send_draws(32'h0000_0002, 32'h0000_0001);
    drain_results();
    // no selection: equal fitness, fractions alone decide
    write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0001);
    send_draws(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    send_draws(32'h0000_0003, 32'h8000_0001);
    drain_results();
  endtask

  // random phases with random registers, bursty sender, one long receiver hold
  // and a sender pause after each phase until everything is back
  task automatic test_random_steps();
    int burst_left;
    int sent;
    int phase_len;
    burst_left = 0;
    sent       = 0;
    while (sent < RANDOM_WORDS) begin
      // mostly mild payoffs and crowding so the population keeps growing
      if ($urandom_range(0, 9) == 0)
        write_all_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom_range(0, 40)));
      else
        write_all_regs(16'($urandom_range(0, 8191) - 4096),
                       16'($urandom_range(0, 8191) - 4096),
                       16'($urandom_range(0, 8191) - 4096),
                       16'($urandom_range(0, 8191) - 4096),
                       16'($urandom), 16'($urandom), 16'($urandom_range(0, 40)));
      phase_len = $urandom_range(80, 200);
      if (sent == 0) begin
        hold_asks++;                      // sender keeps offering during the hold
        for (int i = 0; i < 6; i++) send_draws($urandom, $urandom);
        sent += 6;
      end
      for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++) begin
        if (burst_left == 0) begin
          sender_gap($urandom_range(0, 3) == 0 ? $urandom_range(0, 700)
                                               : $urandom_range(0, 20));
          burst_left = $urandom_range(1, 12);
        end
        send_draws($urandom_range(0, 15) == 0 ? $urandom_range(0, 3) : $urandom, $urandom);
        burst_left--;
        sent++;
      end
      drain_results();
    end
  endtask

  // crowding so strong that both rates clamp to zero: no event, time saturates
  task automatic test_zero_rate();
    write_all_regs(16'd8192, 16'hF000, 16'd12288, 16'd0, 16'd6554, 16'd0, 16'hFFFF);
    send_draws(32'h0000_0001, 32'h0000_0000);
    send_draws(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
    // back to growth: time stays at its ceiling
    write_all_regs(16'd8192, 16'hF000, 16'd12288, 16'd0, 16'd6554, 16'd2560, 16'd0);
    send_draws(32'h0000_0000, 32'h1000_0000);
    send_draws(32'h0000_0001, 32'hF000_0000);
    drain_results();
  endtask

  initial begin
    reset_population_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_draws();
    test_register_extremes();
    test_random_steps();
    test_zero_rate();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("** gillespie_two_species_birth_step_core: PASSED **");
    end else begin
      $display("** gillespie_two_species_birth_step_core: FAILED **");
    end
    $finish;
  end

endmodule
